/* src/u8vd_pkg.sv */
// ----------------------------------------------------------------------------
// u8vd_pkg
// Types and constants shared by the UTF-8 validating decoder.
// ----------------------------------------------------------------------------
package u8vd_pkg;

    localparam int unsigned CP_W  = 21;
    localparam int unsigned CNT_W = 3;

    // byte classes
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_TAG   = 8'h80;
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_TAG  = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_TAG  = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_TAG  = 8'hF0;
    localparam logic [7:0] PAYLOAD_MASK = 8'h3F;

    // sequence lengths
    localparam logic [2:0] SEQ_NONE = 3'd0;
    localparam logic [2:0] SEQ_ONE  = 3'd1;
    localparam logic [2:0] SEQ_TWO  = 3'd2;
    localparam logic [2:0] SEQ_THREE = 3'd3;
    localparam logic [2:0] SEQ_FOUR = 3'd4;

    // value limits
    localparam logic [CP_W-1:0] MIN_TWO   = 21'h00080;
    localparam logic [CP_W-1:0] MIN_THREE = 21'h00800;
    localparam logic [CP_W-1:0] MIN_FOUR  = 21'h10000;
    localparam logic [CP_W-1:0] SURR_LO   = 21'h0D800;
    localparam logic [CP_W-1:0] SURR_HI   = 21'h0DFFF;
    localparam logic [CP_W-1:0] MAX_CP    = 21'h10FFFF;

    // results caused by one request: err_count error results, then at most
    // one tail result (a valid code point)
    typedef struct packed {
        logic [2:0]       err_count;
        logic             tail_valid;
        logic [CP_W-1:0]  tail_cp;
        logic [CNT_W-1:0] tail_cnt;
    } bundle_t;

    function automatic logic [2:0] lead_len(input logic [7:0] b);
        logic [2:0] len;
        len = SEQ_NONE;
        if ((b & LEAD2_MASK) == LEAD2_TAG) begin
            len = SEQ_TWO;
        end
        else if ((b & LEAD3_MASK) == LEAD3_TAG) begin
            len = SEQ_THREE;
        end
        else if ((b & LEAD4_MASK) == LEAD4_TAG) begin
            len = SEQ_FOUR;
        end
        return len;
    endfunction

endpackage

/* src/u8vd_if.sv */
// ----------------------------------------------------------------------------
// u8vd channel interfaces
// Byte request channel and decoded result channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface u8vd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_text;

    modport source (output valid, output data_byte, output end_of_text, input ready);
    modport sink   (input valid, input data_byte, input end_of_text, output ready);
endinterface

interface u8vd_cp_if;
    logic                        valid;
    logic                        ready;
    logic [u8vd_pkg::CP_W-1:0]   code_point;
    logic                        is_error;
    logic [u8vd_pkg::CNT_W-1:0]  byte_count;
    logic                        last_of_run;

    modport source (output valid, output code_point, output is_error,
                    output byte_count, output last_of_run, input ready);
    modport sink   (input valid, input code_point, input is_error,
                    input byte_count, input last_of_run, output ready);
endinterface

/* src/u8vd_decode.sv */
// ----------------------------------------------------------------------------
// u8vd_decode
// Sequence state and per-byte decode: turns one request into a result bundle.
// ----------------------------------------------------------------------------
module u8vd_decode (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_text,
    output u8vd_pkg::bundle_t    bundle
);

    logic [7:0] held_reg [3];
    logic [7:0] held_next [3];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [2:0] exp_len_reg;
    logic [2:0] exp_len_next;

    logic                      is_cont;
    logic [2:0]                lead_len;
    logic [u8vd_pkg::CP_W-1:0] seq_cp;
    logic                      seq_ok;

    assign is_cont  = (data_byte & u8vd_pkg::CONT_MASK) == u8vd_pkg::CONT_TAG;
    assign lead_len = u8vd_pkg::lead_len(data_byte);

    // value of the sequence closed by this byte
    always_comb
    begin
        seq_cp = '0;
        seq_ok = 1'b0;
        unique case (exp_len_reg)
            u8vd_pkg::SEQ_TWO:
            begin
                seq_cp = {10'd0, held_reg[0][4:0], data_byte[5:0]};
                seq_ok = seq_cp >= u8vd_pkg::MIN_TWO;
            end
            u8vd_pkg::SEQ_THREE:
            begin
                seq_cp = {5'd0, held_reg[0][3:0], held_reg[1][5:0], data_byte[5:0]};
                seq_ok = (seq_cp >= u8vd_pkg::MIN_THREE)
                      && !((seq_cp >= u8vd_pkg::SURR_LO) && (seq_cp <= u8vd_pkg::SURR_HI));
            end
            u8vd_pkg::SEQ_FOUR:
            begin
                seq_cp = {held_reg[0][2:0], held_reg[1][5:0], held_reg[2][5:0],
                          data_byte[5:0]};
                seq_ok = (seq_cp >= u8vd_pkg::MIN_FOUR) && (seq_cp <= u8vd_pkg::MAX_CP);
            end
            default:
            begin
                seq_cp = '0;
                seq_ok = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        held_next       = held_reg;
        held_count_next = held_count_reg;
        exp_len_next    = exp_len_reg;
        bundle          = '0;

        if ((held_count_reg == 2'd0) || !is_cont) begin
            // held bytes, if any, are broken by this byte
            bundle.err_count = {1'b0, held_count_reg};
            held_count_next  = 2'd0;
            exp_len_next     = u8vd_pkg::SEQ_NONE;
            if (!data_byte[7]) begin
                bundle.tail_valid = 1'b1;
                bundle.tail_cp    = {13'd0, data_byte};
                bundle.tail_cnt   = u8vd_pkg::SEQ_ONE;
            end
            else if (lead_len == u8vd_pkg::SEQ_NONE) begin
                bundle.err_count = bundle.err_count + 3'd1;
            end
            else if (end_of_text) begin
                // new lead at end of text flushes at once
                bundle.err_count = bundle.err_count + 3'd1;
            end
            else begin
                held_next[0]    = data_byte;
                held_count_next = 2'd1;
                exp_len_next    = lead_len;
            end
        end
        else if ({1'b0, held_count_reg} + 3'd1 == exp_len_reg) begin
            held_count_next = 2'd0;
            exp_len_next    = u8vd_pkg::SEQ_NONE;
            if (seq_ok) begin
                bundle.tail_valid = 1'b1;
                bundle.tail_cp    = seq_cp;
                bundle.tail_cnt   = exp_len_reg;
            end
            else begin
                bundle.err_count = exp_len_reg;
            end
        end
        else begin
            held_next[held_count_reg] = data_byte;
            held_count_next = held_count_reg + 2'd1;
            if (end_of_text) begin
                bundle.err_count = {1'b0, held_count_reg} + 3'd1;
                held_count_next  = 2'd0;
                exp_len_next     = u8vd_pkg::SEQ_NONE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            held_reg[0]    <= '0;
            held_reg[1]    <= '0;
            held_reg[2]    <= '0;
            held_count_reg <= '0;
            exp_len_reg    <= u8vd_pkg::SEQ_NONE;
        end
        else if (accept) begin
            held_reg       <= held_next;
            held_count_reg <= held_count_next;
            exp_len_reg    <= exp_len_next;
        end
    end

endmodule

/* src/u8vd_emit.sv */
// ----------------------------------------------------------------------------
// u8vd_emit
// Result register: holds one bundle and hands its results out one per cycle while code is ready.
// ----------------------------------------------------------------------------
module u8vd_emit (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  u8vd_pkg::bundle_t bundle,
    output logic              take,
    u8vd_cp_if.source         code
);

    logic [2:0]                 err_left_reg;
    logic [2:0]                 err_left_next;
    logic                       tail_valid_reg;
    logic                       tail_valid_next;
    logic [u8vd_pkg::CP_W-1:0]  tail_cp_reg;
    logic [u8vd_pkg::CNT_W-1:0] tail_cnt_reg;

    logic pending;
    logic last;
    logic fire;

    assign pending = (err_left_reg != 3'd0) || tail_valid_reg;
    assign last    = ((err_left_reg == 3'd1) && !tail_valid_reg)
                  || ((err_left_reg == 3'd0) && tail_valid_reg);
    assign fire    = code.valid && code.ready;

    // a new request may enter while the final result leaves
    assign take = !pending || (fire && last);

    assign code.valid       = pending;
    assign code.is_error    = err_left_reg != 3'd0;
    assign code.code_point  = (err_left_reg != 3'd0) ? '0 : tail_cp_reg;
    assign code.byte_count  = (err_left_reg != 3'd0) ? u8vd_pkg::SEQ_ONE : tail_cnt_reg;
    assign code.last_of_run = last;

    always_comb
    begin
        err_left_next   = err_left_reg;
        tail_valid_next = tail_valid_reg;
        if (fire) begin
            if (err_left_reg != 3'd0) begin
                err_left_next = err_left_reg - 3'd1;
            end
            else begin
                tail_valid_next = 1'b0;
            end
        end
        if (load) begin
            err_left_next   = bundle.err_count;
            tail_valid_next = bundle.tail_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            err_left_reg   <= '0;
            tail_valid_reg <= 1'b0;
        end
        else begin
            err_left_reg   <= err_left_next;
            tail_valid_reg <= tail_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            tail_cp_reg  <= bundle.tail_cp;
            tail_cnt_reg <= bundle.tail_cnt;
        end
    end

endmodule

/* src/utf8_validating_decoder_unit.sv */
// ----------------------------------------------------------------------------
// utf8_validating_decoder_unit
// UTF-8 to code point decoder with rejection of malformed input.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                          handshake
//  text     in   data_byte[7:0], end_of_text                      valid/ready
//  code     out  code_point[20:0], is_error, byte_count[2:0],     valid/ready
//                last_of_run
//
// one byte is decoded in the cycle it is taken; its results sit in the result
// register and leave one per cycle while code is ready, and text is held until
// the final result has left; a byte with no results does not hold text
// the next byte is taken in the same cycle the final result of the previous
// one is taken
// reset clears the held sequence and drops any pending results
// ----------------------------------------------------------------------------
module utf8_validating_decoder_unit (
    input  logic        clk,
    input  logic        rst_n,
    u8vd_byte_if.sink   text,
    u8vd_cp_if.source   code
);

    u8vd_pkg::bundle_t bundle;
    logic              take;
    logic              accept;

    assign text.ready = take;
    assign accept     = text.valid && take;

    u8vd_decode u_decode (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .data_byte   (text.data_byte),
        .end_of_text (text.end_of_text),
        .bundle      (bundle)
    );

    u8vd_emit u_emit (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .bundle (bundle),
        .take   (take),
        .code   (code)
    );

endmodule
